// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own logic (the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked outside reset
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/mbsd_pkg.sv =====
// Package: request and result codes and shared status types for the debouncer
package mbsd_pkg;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_IRQ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_UP     = 2'd0,
    KIND_DOWN   = 2'd1,
    KIND_STATUS = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic settled;
    logic busy;
  } scan_flags_t;

endpackage

// ===== rtl/mbsd_emit.sv =====
// Result buffer: holds one scan's outcome and sends its event beats, then the status beat
module mbsd_emit #(
  parameter int NUM_BUTTONS = 6,
  parameter int IDX_W       = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [NUM_BUTTONS-1:0]     ev_mask_in,
  input  logic [NUM_BUTTONS-1:0]     ev_up_in,
  input  logic [NUM_BUTTONS-1:0]     sample_in,
  input  logic [NUM_BUTTONS-1:0]     stable_in,
  input  mbsd_pkg::scan_flags_t      flags_in,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 result_kind,
  output logic [IDX_W-1:0]           button_index,
  output logic [NUM_BUTTONS-1:0]     sample_levels,
  output logic [NUM_BUTTONS-1:0]     stable_levels,
  output logic                       scan_settled,
  output logic                       busy_res,
  output logic                       last
);

  logic                   full;
  logic [NUM_BUTTONS-1:0] ev_mask;
  logic [NUM_BUTTONS-1:0] ev_up;
  logic [NUM_BUTTONS-1:0] sample;
  logic [NUM_BUTTONS-1:0] stable;
  mbsd_pkg::scan_flags_t  flags;
  logic [IDX_W-1:0]       low_idx;
  logic                   take;
  mbsd_pkg::result_kind_t kind;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (ev_mask[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign take      = full && !out_stall;
  assign last      = (ev_mask == '0);
  assign free      = !full || (take && last);
  assign out_valid = full;

  always_comb begin
    if (last) begin
      kind = mbsd_pkg::KIND_STATUS;
    end else if (ev_up[low_idx]) begin
      kind = mbsd_pkg::KIND_UP;
    end else begin
      kind = mbsd_pkg::KIND_DOWN;
    end
  end

  assign result_kind   = kind;
  assign button_index  = last ? '0 : low_idx;
  assign sample_levels = sample;
  assign stable_levels = stable;
  assign scan_settled  = flags.settled;
  assign busy_res      = flags.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take && last) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_mask <= ev_mask_in;
      ev_up   <= ev_up_in;
      sample  <= sample_in;
      stable  <= stable_in;
      flags   <= flags_in;
    end else if (take && !last) begin
      ev_mask <= ev_mask & (ev_mask - NUM_BUTTONS'(1));
    end
  end

endmodule

// ===== rtl/multi_button_shift_debouncer.sv =====
// Top level: shift-history button debouncer with pending-edge sampling
// An interrupt beat gives no result. A scan tick updates all
// histories and stable levels in the cycle it is taken, then the result buffer sends one
// beat per button event, lowest button first, and a closing status beat: a tick gives
// events + 1 beats (1 to NUM_BUTTONS + 1). The next beat of either kind is taken
// in the cycle the status beat leaves; until then the input is stalled.
module multi_button_shift_debouncer #(
  parameter int NUM_BUTTONS  = 6,
  parameter int HISTORY_BITS = 5,
  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  input  logic [NUM_BUTTONS-1:0] edge_flags,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [IDX_W-1:0]       button_index,
  output logic [NUM_BUTTONS-1:0] sample_levels,
  output logic [NUM_BUTTONS-1:0] stable_levels,
  output logic                   scan_settled,
  output logic                   busy_res,
  output logic                   last
);

  logic [HISTORY_BITS-1:0] hist [NUM_BUTTONS];
  logic [HISTORY_BITS-1:0] hist_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  stable;
  logic [NUM_BUTTONS-1:0]  stable_next;
  logic [NUM_BUTTONS-1:0]  pending;
  logic                    busy;
  logic                    busy_next;
  logic [NUM_BUTTONS-1:0]  sample;
  logic [NUM_BUTTONS-1:0]  ev_up;
  logic [NUM_BUTTONS-1:0]  ev_down;
  logic [NUM_BUTTONS-1:0]  quiet;
  logic                    settled;
  logic                    free;
  logic                    in_take;
  logic                    tick_take;
  logic                    irq_take;
  mbsd_pkg::scan_flags_t   flags;

  assign in_stall  = !free;
  assign in_take   = in_valid && !in_stall;
  assign tick_take = in_take && (req_type == mbsd_pkg::REQ_TICK);
  assign irq_take  = in_take && (req_type == mbsd_pkg::REQ_IRQ);

  assign sample = (pending != '0) ? (stable ^ pending) : pin_levels;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hist_next[i] = {hist[i][HISTORY_BITS-2:0], sample[i]};
      ev_up[i]     = !stable[i] && (&hist_next[i]);
      ev_down[i]   = stable[i] && !(|hist_next[i]);
      quiet[i]     = (&hist_next[i]) || !(|hist_next[i]);
    end
  end

  assign settled     = &quiet;
  assign stable_next = stable ^ (ev_up | ev_down);
  assign busy_next   = settled ? 1'b0 : busy;
  assign flags       = '{settled: settled, busy: busy_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist[i] <= '1;
      end
      stable  <= '1;
      pending <= '0;
      busy    <= 1'b0;
    end else if (tick_take) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist[i] <= hist_next[i];
      end
      stable  <= stable_next;
      pending <= '0;
      busy    <= busy_next;
    end else if (irq_take) begin
      pending <= pending | edge_flags;
      if (edge_flags != '0) begin
        busy <= 1'b1;
      end
    end
  end

  mbsd_emit #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (tick_take),
    .ev_mask_in    (ev_up | ev_down),
    .ev_up_in      (ev_up),
    .sample_in     (sample),
    .stable_in     (stable_next),
    .flags_in      (flags),
    .free          (free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .button_index  (button_index),
    .sample_levels (sample_levels),
    .stable_levels (stable_levels),
    .scan_settled  (scan_settled),
    .busy_res      (busy_res),
    .last          (last)
  );

`include "assert_macros.svh"

  `CHK_NOW(a_pending_busy, pending != '0, busy)
  `CHK_NEXT(a_tick_out, tick_take, out_valid)
  `CHK_NEXT(a_drain, out_valid && !out_stall && last && !tick_take, !out_valid)

endmodule

// ===== tb/multi_button_shift_debouncer_tb.sv =====
// Testbench for the shift-history button debouncer: directed table, random bursts, beat checks
`timescale 1ns / 100ps

module multi_button_shift_debouncer_tb;

  localparam int NUM_BTN = 6;
  localparam int HIST_W = 5;
  localparam logic [HIST_W-1:0] HIST_ALL = 5'h1f;
  localparam logic [HIST_W-1:0] HIST_NONE = 5'h00;
  localparam int LONG_HOLD = 80;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    mbsd_pkg::result_kind_t kind;
    logic [2:0] idx;
    logic [NUM_BTN-1:0] sample;
    logic [NUM_BTN-1:0] stable;
    logic settled;
    logic busy;
    logic last;
  } scan_beat_t;

  typedef struct packed {
    logic req;
    logic [NUM_BTN-1:0] pins;
    logic [NUM_BTN-1:0] flags;
    logic typed;
    logic [NUM_BTN-1:0] t_sample;
    logic [NUM_BTN-1:0] t_stable;
    logic t_settled;
    logic t_busy;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b1, 6'h3f, 6'h3f, 1'b1, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h3f, 1'b1, 6'h00, 6'h3f, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h00, 1'b1, 6'h00, 6'h00, 1'b1, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h00, 6'h3f, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h00, 6'h00, 1'b1, 6'h3f, 6'h00, 1'b0, 1'b1},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h2a, 6'h15, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h15, 6'h2a, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h15, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h2a, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h15, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h2a, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h15, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h00, 6'h01, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_IRQ,  6'h00, 6'h20, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0},
    '{mbsd_pkg::REQ_TICK, 6'h3f, 6'h00, 1'b0, 6'h00, 6'h00, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [NUM_BTN-1:0] pin_levels;
  logic [NUM_BTN-1:0] edge_flags;
  logic out_valid;
  logic out_stall;
  logic [1:0] result_kind;
  logic [2:0] button_index;
  logic [NUM_BTN-1:0] sample_levels;
  logic [NUM_BTN-1:0] stable_levels;
  logic scan_settled;
  logic busy_res;
  logic last;

  logic [HIST_W-1:0] deb_history [NUM_BTN];
  logic [NUM_BTN-1:0] deb_stable;
  logic [NUM_BTN-1:0] deb_pending;
  logic deb_busy;

  scan_beat_t awaited_beats [$];
  int errors = 0;
  bit calm = 0;
  bit hold_off_req = 0;

  multi_button_shift_debouncer #(
    .NUM_BUTTONS(NUM_BTN),
    .HISTORY_BITS(HIST_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .pin_levels(pin_levels),
    .edge_flags(edge_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .button_index(button_index),
    .sample_levels(sample_levels),
    .stable_levels(stable_levels),
    .scan_settled(scan_settled),
    .busy_res(busy_res),
    .last(last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic debounce_scan(input logic req, input logic [NUM_BTN-1:0] pins,
                               input logic [NUM_BTN-1:0] flags);
    logic [NUM_BTN-1:0] smp;
    logic [HIST_W-1:0] h;
    logic settled;
    mbsd_pkg::result_kind_t ev_kind [$];
    int ev_idx [$];
    scan_beat_t b;
    if (req == mbsd_pkg::REQ_IRQ) begin
      deb_pending = deb_pending | flags;
      if (flags != '0) deb_busy = 1'b1;
      return;
    end
    smp = (deb_pending != '0) ? (deb_stable ^ deb_pending) : pins;
    deb_pending = '0;
    settled = 1'b1;
    for (int i = 0; i < NUM_BTN; i++) begin
      h = {deb_history[i][HIST_W-2:0], smp[i]};
      deb_history[i] = h;
      if (!deb_stable[i] && h == HIST_ALL) begin
        deb_stable[i] = 1'b1;
        ev_kind.push_back(mbsd_pkg::KIND_UP);
        ev_idx.push_back(i);
      end else if (deb_stable[i] && h == HIST_NONE) begin
        deb_stable[i] = 1'b0;
        ev_kind.push_back(mbsd_pkg::KIND_DOWN);
        ev_idx.push_back(i);
      end else if (h != HIST_NONE && h != HIST_ALL) begin
        settled = 1'b0;
      end
    end
    if (settled) deb_busy = 1'b0;
    b.sample = smp;
    b.stable = deb_stable;
    b.settled = settled;
    b.busy = deb_busy;
    b.last = 1'b0;
    for (int k = 0; k < ev_kind.size(); k++) begin
      b.kind = ev_kind[k];
      b.idx = 3'(ev_idx[k]);
      awaited_beats.push_back(b);
    end
    b.kind = mbsd_pkg::KIND_STATUS;
    b.idx = '0;
    b.last = 1'b1;
    awaited_beats.push_back(b);
  endtask

  task automatic send_beat(input logic req, input logic [NUM_BTN-1:0] pins,
                           input logic [NUM_BTN-1:0] flags);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    pin_levels <= pins;
    edge_flags <= flags;
    do @(posedge clk); while (in_stall);
    debounce_scan(req, pins, flags);
  endtask

  task automatic drain_beats();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_beats.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : beat_check
    scan_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected beat expected none actual kind %0d", $time, result_kind);
        errors++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("result_kind", 8'(want.kind), 8'(result_kind));
        check_field("button_index", 8'(want.idx), 8'(button_index));
        check_field("sample_levels", 8'(want.sample), 8'(sample_levels));
        check_field("stable_levels", 8'(want.stable), 8'(stable_levels));
        check_field("scan_settled", 8'(want.settled), 8'(scan_settled));
        check_field("busy_res", 8'(want.busy), 8'(busy_res));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : sender
    int sent;
    int len;
    int r;
    bit did_hold;
    bit did_pause;
    logic [NUM_BTN-1:0] target;
    logic [NUM_BTN-1:0] bounce;
    scan_beat_t b;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= mbsd_pkg::REQ_TICK;
    pin_levels <= '0;
    edge_flags <= '0;
    for (int i = 0; i < NUM_BTN; i++) deb_history[i] = HIST_ALL;
    deb_stable = '1;
    deb_pending = '0;
    deb_busy = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(DIR_TABLE[i].req, DIR_TABLE[i].pins, DIR_TABLE[i].flags);
      if (DIR_TABLE[i].typed) begin
        b = awaited_beats[awaited_beats.size() - 1];
        b.sample = DIR_TABLE[i].t_sample;
        b.stable = DIR_TABLE[i].t_stable;
        b.settled = DIR_TABLE[i].t_settled;
        b.busy = DIR_TABLE[i].t_busy;
        awaited_beats[awaited_beats.size() - 1] = b;
      end
    end

    sent = 0;
    did_hold = 0;
    did_pause = 0;
    while (sent < RANDOM_ITEMS) begin
      if (!did_hold && sent >= 90) begin
        did_hold = 1;
        calm = 1;
        hold_off_req = 1;
      end else if ($urandom_range(0, 5) == 0) begin
        calm = !calm;
      end
      if (!did_pause && sent >= 170) begin
        did_pause = 1;
        drain_beats();
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        // hold a level with occasional bounce so histories settle
        target = NUM_BTN'($urandom);
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_beat(mbsd_pkg::REQ_IRQ, NUM_BTN'($urandom),
                      ($urandom_range(0, 3) == 0) ? '0 : NUM_BTN'($urandom));
            sent++;
          end
          bounce = ($urandom_range(0, 5) == 0) ? NUM_BTN'($urandom) : '0;
          send_beat(mbsd_pkg::REQ_TICK, target ^ bounce, NUM_BTN'($urandom));
          sent++;
        end
      end else if (r == 7) begin
        send_beat(mbsd_pkg::REQ_IRQ, NUM_BTN'($urandom), NUM_BTN'($urandom));
        sent++;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_beat(mbsd_pkg::REQ_TICK, NUM_BTN'($urandom), NUM_BTN'($urandom));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_beat(($urandom_range(0, 3) == 0) ? mbsd_pkg::REQ_IRQ : mbsd_pkg::REQ_TICK,
                    NUM_BTN'($urandom), NUM_BTN'($urandom));
          sent++;
        end
      end
    end

    calm = 0;
    drain_beats();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbsd_pkg.sv
rtl/mbsd_emit.sv
rtl/multi_button_shift_debouncer.sv
tb/multi_button_shift_debouncer_tb.sv
